// File: rtl/b58d_pkg.sv
// Shared constants and types for the base58 stream decoder.
package b58d_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned DIGIT_W    = 6;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned COUNT_SAT  = 12;
  localparam int unsigned MAX_DIGITS = 11;

  localparam logic [CHAR_W-1:0] CH_1 = 8'h31;  // '1'
  localparam logic [CHAR_W-1:0] CH_9 = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_a = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_k = 8'h6b;  // 'k'
  localparam logic [CHAR_W-1:0] CH_m = 8'h6d;  // 'm'
  localparam logic [CHAR_W-1:0] CH_z = 8'h7a;  // 'z'
  localparam logic [CHAR_W-1:0] CH_A = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CH_H = 8'h48;  // 'H'
  localparam logic [CHAR_W-1:0] CH_J = 8'h4a;  // 'J'
  localparam logic [CHAR_W-1:0] CH_N = 8'h4e;  // 'N'
  localparam logic [CHAR_W-1:0] CH_P = 8'h50;  // 'P'
  localparam logic [CHAR_W-1:0] CH_Z = 8'h5a;  // 'Z'

  // Digit offsets of each alphabet run.
  localparam logic [CHAR_W-1:0] OFS_a = 8'd9;
  localparam logic [CHAR_W-1:0] OFS_m = 8'd20;
  localparam logic [CHAR_W-1:0] OFS_A = 8'd34;
  localparam logic [CHAR_W-1:0] OFS_J = 8'd42;
  localparam logic [CHAR_W-1:0] OFS_P = 8'd47;

  typedef struct packed {
    logic               valid;
    logic [DIGIT_W-1:0] digit;
  } dig_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               ok;
  } res_t;

endpackage

// File: rtl/b58d_digit.sv
// Character to base58 digit lookup with an alphabet membership flag.
module b58d_digit (
  input  logic [b58d_pkg::CHAR_W-1:0] char_code,
  output b58d_pkg::dig_t              dig
);

  logic [b58d_pkg::CHAR_W-1:0] d8;

  always_comb begin
    dig.valid = 1'b1;
    d8        = '0;
    if (char_code >= b58d_pkg::CH_1 && char_code <= b58d_pkg::CH_9) begin
      d8 = char_code - b58d_pkg::CH_1;
    end else if (char_code >= b58d_pkg::CH_a && char_code <= b58d_pkg::CH_k) begin
      d8 = char_code - b58d_pkg::CH_a + b58d_pkg::OFS_a;
    end else if (char_code >= b58d_pkg::CH_m && char_code <= b58d_pkg::CH_z) begin
      d8 = char_code - b58d_pkg::CH_m + b58d_pkg::OFS_m;
    end else if (char_code >= b58d_pkg::CH_A && char_code <= b58d_pkg::CH_H) begin
      d8 = char_code - b58d_pkg::CH_A + b58d_pkg::OFS_A;
    end else if (char_code >= b58d_pkg::CH_J && char_code <= b58d_pkg::CH_N) begin
      d8 = char_code - b58d_pkg::CH_J + b58d_pkg::OFS_J;
    end else if (char_code >= b58d_pkg::CH_P && char_code <= b58d_pkg::CH_Z) begin
      d8 = char_code - b58d_pkg::CH_P + b58d_pkg::OFS_P;
    end else begin
      dig.valid = 1'b0;
    end
    dig.digit = d8[b58d_pkg::DIGIT_W-1:0];
  end

endmodule

// File: rtl/b58d_accum.sv
// String state: accumulator, saturating character count and error flag.
module b58d_accum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 last_char,
  input  b58d_pkg::dig_t       dig,
  output b58d_pkg::res_t       res
);

  logic [b58d_pkg::VALUE_W-1:0] acc_r, acc_nxt, acc_upd, acc_mul;
  logic [b58d_pkg::CNT_W-1:0]   cnt_r, cnt_nxt, cnt_upd;
  logic                         bad_r, bad_nxt, bad_upd;

  always_comb begin
    // acc * 58 = acc * 64 - acc * 4 - acc * 2
    acc_mul = (acc_r << 6) - (acc_r << 2) - (acc_r << 1);
    acc_upd = dig.valid
      ? acc_mul + {{(b58d_pkg::VALUE_W-b58d_pkg::DIGIT_W){1'b0}}, dig.digit}
      : acc_r;
    cnt_upd = (cnt_r == b58d_pkg::CNT_W'(b58d_pkg::COUNT_SAT))
      ? cnt_r : cnt_r + 1'b1;
    bad_upd = bad_r | ~dig.valid;

    res.ok    = ~bad_upd && (cnt_upd <= b58d_pkg::CNT_W'(b58d_pkg::MAX_DIGITS));
    res.value = res.ok ? acc_upd : '0;

    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    bad_nxt = bad_r;
    if (step) begin
      if (last_char) begin
        acc_nxt = '0;
        cnt_nxt = '0;
        bad_nxt = 1'b0;
      end else begin
        acc_nxt = acc_upd;
        cnt_nxt = cnt_upd;
        bad_nxt = bad_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      bad_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      bad_r <= bad_nxt;
    end
  end

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= b58d_pkg::CNT_W'(b58d_pkg::COUNT_SAT))
    else $error("character count beyond saturation");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_char |=> acc_r == '0 && cnt_r == '0 && !bad_r)
    else $error("string state not cleared after last character");

endmodule

// File: rtl/base58_decode_u64_stream.sv
// Top level of the streaming base58 to 64-bit unsigned decoder.
//
// Input channel (in_valid/in_ready): one ASCII character per request in
// in_char_code; in_last_char marks the final character of a string.
// Alphabet: 1-9, a-k, m-z, A-H, J-N, P-Z (digits 0..57 in that order).
// Result channel (out_valid/out_ready): one request per string, carrying
// out_value (acc = acc*58 + digit, modulo 2^64) and out_ok. out_ok is low
// and out_value zero when any character was outside the alphabet or the
// string held more than eleven characters.
// Throughput: one character per cycle, sustained while a last character
// is not held back by a full result register. The accumulator update
// (a constant multiply by 58 built from shifts, plus the digit) is the
// loop that sets this rate. A last character passes the input register,
// then the result register, before its result shows on out_valid.
// Reset (rst_n low, synchronous): both registers empty, string state clear.
// Stall: while out_valid waits for out_ready, non-last characters keep
// flowing into the accumulator; a last character holds in the input
// register until the result register frees up, and in_ready drops behind it.
module base58_decode_u64_stream (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [b58d_pkg::CHAR_W-1:0]        in_char_code,
  input  logic                               in_last_char,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [b58d_pkg::VALUE_W-1:0]       out_value,
  output logic                               out_ok
);

  // Input register.
  logic                        iv_r, iv_nxt;
  logic [b58d_pkg::CHAR_W-1:0] ichar_r;
  logic                        ilast_r;

  // Result register.
  logic                         ov_r, ov_nxt;
  logic [b58d_pkg::VALUE_W-1:0] oval_r;
  logic                         ook_r;

  b58d_pkg::dig_t dig;
  b58d_pkg::res_t res;
  logic           step;
  logic           load_out;

  b58d_digit u_digit (
    .char_code (ichar_r),
    .dig       (dig)
  );

  b58d_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .last_char (ilast_r),
    .dig       (dig),
    .res       (res)
  );

  always_comb begin
    // Advance the held character unless it ends a string and the
    // result register is still occupied.
    step     = iv_r && (!ilast_r || !ov_r || out_ready);
    load_out = step && ilast_r;
    in_ready = !iv_r || step;
    iv_nxt   = in_ready ? in_valid : iv_r;
    ov_nxt   = load_out ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      iv_r <= iv_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ichar_r <= in_char_code;
      ilast_r <= in_last_char;
    end
    if (load_out) begin
      oval_r <= res.value;
      ook_r  <= res.ok;
    end
  end

  assign out_valid = ov_r;
  assign out_value = oval_r;
  assign out_ok    = ook_r;

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_value == '0)
    else $error("failed string reports a nonzero value");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid)
    else $error("last character did not produce a result");

  a_block_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> iv_r && ilast_r && ov_r && !out_ready)
    else $error("input blocked without a pending result");

endmodule
